// ===== hw/rtl/cfp_pkg.sv =====
// Shared types and constants for the command frame parser.
// Holds the parse phase and beat kind enums, the queue token, status codes
// and the CRC-16/CCITT-FALSE byte update. No dependencies.
`default_nettype none

package cfp_pkg;

	// Sync pair and CRC constants.
	localparam logic [7:0]  SYNC_FIRST  = 8'hA5;
	localparam logic [7:0]  SYNC_SECOND = 8'h5A;
	localparam logic [15:0] CRC_INIT    = 16'hFFFF;
	localparam logic [15:0] CRC_POLY    = 16'h1021;
	localparam logic [15:0] CRC_MSB     = 16'h8000;

	// Configuration register indexes.
	localparam logic CFG_VERSION = 1'b0;
	localparam logic CFG_TYPE    = 1'b1;

	// Queue between front and back.
	localparam int QDEPTH = 4;
	localparam int QAW    = 2;

	// Parse phases of the front end.
	typedef enum logic [3:0] {
		PH_SYNC1,
		PH_SYNC2,
		PH_VER,
		PH_TYPE,
		PH_LEN_LO,
		PH_LEN_HI,
		PH_SEQ0,
		PH_SEQ1,
		PH_SEQ2,
		PH_SEQ3,
		PH_DATA,
		PH_CRC_LO,
		PH_CRC_HI
	} phase_t;

	// What the back end has to do with a beat.
	typedef enum logic [3:0] {
		K_IDLE,
		K_START,
		K_VER,
		K_TYPE,
		K_HDR,
		K_TOO_LONG,
		K_FIRST_DATA,
		K_DATA,
		K_CRC_LO,
		K_CRC_HI
	} kind_t;

	// Frame status codes.
	typedef enum logic [2:0] {
		ST_BUSY     = 3'd0,
		ST_ACCEPT   = 3'd1,
		ST_CRC_BAD  = 3'd2,
		ST_NOT_CMD  = 3'd3,
		ST_TOO_LONG = 3'd4
	} status_t;

	// One classified beat.
	typedef struct packed {
		logic [7:0] data;
		kind_t      kind;
		logic       len_one;
	} token_t;

	// CRC-16/CCITT-FALSE update over one byte, MSB first.
	function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {b, 8'h00};
		for (int i = 0; i < 8; i++) begin
			if ((c & CRC_MSB) != 16'h0000) begin
				c = {c[14:0], 1'b0} ^ CRC_POLY;
			end else begin
				c = {c[14:0], 1'b0};
			end
		end
		return c;
	endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/cfp_front.sv =====
// Front end of the command frame parser: tracks the parse phase, the frame
// length and the payload count, and tags every byte with its kind.
// Depends on cfp_pkg.
`default_nettype none

module cfp_front #(
	parameter int MAX_PAYLOAD = 4
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	input  wire logic [7:0]    in_byte,
	output cfp_pkg::token_t    tok
);
	import cfp_pkg::*;

	localparam int LW = $clog2(MAX_PAYLOAD + 1);

	phase_t          phase_q;
	phase_t          phase_nxt;
	logic [7:0]      len_lo_q;
	logic [LW-1:0]   len_q;
	logic [LW-1:0]   count_q;
	logic [LW-1:0]   count_inc;
	logic            too_long;

	assign too_long  = {in_byte, len_lo_q} > 16'(MAX_PAYLOAD);
	assign count_inc = count_q + LW'(1);

	// Next parse phase for the current byte.
	always_comb begin
		phase_nxt = phase_q;
		case (phase_q)
			PH_SYNC1: begin
				if (in_byte == SYNC_FIRST) phase_nxt = PH_SYNC2;
			end
			PH_SYNC2: begin
				if (in_byte == SYNC_SECOND) phase_nxt = PH_VER;
				else if (in_byte == SYNC_FIRST) phase_nxt = PH_SYNC2;
				else phase_nxt = PH_SYNC1;
			end
			PH_VER:    phase_nxt = PH_TYPE;
			PH_TYPE:   phase_nxt = PH_LEN_LO;
			PH_LEN_LO: phase_nxt = PH_LEN_HI;
			PH_LEN_HI: phase_nxt = too_long ? PH_SYNC1 : PH_SEQ0;
			PH_SEQ0:   phase_nxt = PH_SEQ1;
			PH_SEQ1:   phase_nxt = PH_SEQ2;
			PH_SEQ2:   phase_nxt = PH_SEQ3;
			PH_SEQ3:   phase_nxt = (len_q == '0) ? PH_CRC_LO : PH_DATA;
			PH_DATA: begin
				if (count_inc >= len_q) phase_nxt = PH_CRC_LO;
			end
			PH_CRC_LO: phase_nxt = PH_CRC_HI;
			PH_CRC_HI: phase_nxt = PH_SYNC1;
			default:   phase_nxt = PH_SYNC1;
		endcase
	end

	// Beat classification handed to the back end.
	always_comb begin
		tok.data    = in_byte;
		tok.len_one = (len_q == LW'(1));
		tok.kind    = K_IDLE;
		case (phase_q)
			PH_SYNC1:  tok.kind = K_IDLE;
			PH_SYNC2:  tok.kind = (in_byte == SYNC_SECOND) ? K_START : K_IDLE;
			PH_VER:    tok.kind = K_VER;
			PH_TYPE:   tok.kind = K_TYPE;
			PH_LEN_LO: tok.kind = K_HDR;
			PH_LEN_HI: tok.kind = too_long ? K_TOO_LONG : K_HDR;
			PH_SEQ0, PH_SEQ1, PH_SEQ2, PH_SEQ3: tok.kind = K_HDR;
			PH_DATA:   tok.kind = (count_q == '0) ? K_FIRST_DATA : K_DATA;
			PH_CRC_LO: tok.kind = K_CRC_LO;
			PH_CRC_HI: tok.kind = K_CRC_HI;
			default:   tok.kind = K_IDLE;
		endcase
	end

	// Phase, length and count registers advance on each accepted beat.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_SYNC1;
			len_lo_q <= '0;
			len_q    <= '0;
			count_q  <= '0;
		end else if (in_valid) begin
			phase_q <= phase_nxt;
			case (phase_q)
				PH_SYNC2: count_q <= '0;
				PH_LEN_LO: len_lo_q <= in_byte;
				PH_LEN_HI: begin
					if (too_long) len_q <= '0;
					else len_q <= LW'({in_byte, len_lo_q});
				end
				PH_DATA: count_q <= count_inc;
				PH_CRC_HI: begin
					len_q   <= '0;
					count_q <= '0;
				end
				default: ;
			endcase
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/cfp_queue.sv =====
// Short queue of classified beats between the front and back ends.
// Storage is a small register array read at the head pointer.
// Depends on cfp_pkg.
`default_nettype none

module cfp_queue (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire cfp_pkg::token_t  push_tok,
	output logic                  full,
	output logic                  head_valid,
	input  wire logic             pop,
	output cfp_pkg::token_t       head_tok
);
	import cfp_pkg::*;

	token_t            mem [QDEPTH];
	logic [QAW-1:0]    wr_ptr_q;
	logic [QAW-1:0]    rd_ptr_q;
	logic [QAW:0]      count_q;
	logic              do_push;
	logic              do_pop;

	assign full       = (count_q == (QAW+1)'(QDEPTH));
	assign head_valid = (count_q != '0);
	assign head_tok   = mem[rd_ptr_q];
	assign do_push    = push && !full;
	assign do_pop     = pop && head_valid;

	// Entry storage.
	always_ff @(posedge clk) begin
		if (do_push) mem[wr_ptr_q] <= push_tok;
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) wr_ptr_q <= wr_ptr_q + QAW'(1);
			if (do_pop) rd_ptr_q <= rd_ptr_q + QAW'(1);
			if (do_push && !do_pop) count_q <= count_q + (QAW+1)'(1);
			else if (do_pop && !do_push) count_q <= count_q - (QAW+1)'(1);
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/cfp_back.sv =====
// Back end of the command frame parser: runs the CRC, captures header
// fields and the first payload byte, and registers one result per beat.
// Depends on cfp_pkg.
`default_nettype none

module cfp_back (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             tok_valid,
	input  wire cfp_pkg::token_t  tok,
	output logic                  tok_take,
	input  wire logic [7:0]       expected_version,
	input  wire logic [7:0]       command_type,
	output logic                  out_valid,
	input  wire logic             out_ready,
	output logic                  command_valid,
	output logic [7:0]            command_byte,
	output logic [2:0]            frame_status
);
	import cfp_pkg::*;

	logic [15:0]  crc_q;
	logic [7:0]   ver_q;
	logic [7:0]   type_q;
	logic [7:0]   pay0_q;
	logic [7:0]   crc_lo_q;
	logic         out_valid_q;
	logic         cmd_valid_q;
	logic [7:0]   cmd_byte_q;
	status_t      status_q;

	logic [15:0]  crc_next;
	logic         step;
	logic         rx_match;
	logic         is_cmd;
	status_t      status_nxt;
	logic         valid_nxt;
	logic [7:0]   byte_nxt;

	assign tok_take = !out_valid_q || out_ready;
	assign step     = tok_valid && tok_take;
	assign crc_next = crc16_byte(crc_q, tok.data);
	assign rx_match = ({tok.data, crc_lo_q} == crc_q);
	assign is_cmd   = (ver_q == expected_version) && (type_q == command_type) && tok.len_one;

	// Result of the current beat.
	always_comb begin
		status_nxt = ST_BUSY;
		valid_nxt  = 1'b0;
		byte_nxt   = 8'h00;
		case (tok.kind)
			K_TOO_LONG: status_nxt = ST_TOO_LONG;
			K_CRC_HI: begin
				if (!rx_match) begin
					status_nxt = ST_CRC_BAD;
				end else if (is_cmd) begin
					status_nxt = ST_ACCEPT;
					valid_nxt  = 1'b1;
					byte_nxt   = pay0_q;
				end else begin
					status_nxt = ST_NOT_CMD;
				end
			end
			default: ;
		endcase
	end

	// CRC and captured frame fields.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q    <= '0;
			ver_q    <= '0;
			type_q   <= '0;
			crc_lo_q <= '0;
		end else if (step) begin
			case (tok.kind)
				K_START: crc_q <= CRC_INIT;
				K_VER: begin
					ver_q <= tok.data;
					crc_q <= crc_next;
				end
				K_TYPE: begin
					type_q <= tok.data;
					crc_q  <= crc_next;
				end
				K_HDR, K_FIRST_DATA, K_DATA: crc_q <= crc_next;
				K_TOO_LONG: begin
					crc_q    <= '0;
					crc_lo_q <= '0;
				end
				K_CRC_LO: crc_lo_q <= tok.data;
				K_CRC_HI: begin
					crc_q    <= '0;
					crc_lo_q <= '0;
				end
				default: ;
			endcase
		end
	end

	// First payload byte of the frame.
	always_ff @(posedge clk) begin
		if (step && tok.kind == K_FIRST_DATA) pay0_q <= tok.data;
	end

	// Output register; refills while the current beat is being taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (tok_take) begin
			out_valid_q <= tok_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			cmd_valid_q <= valid_nxt;
			cmd_byte_q  <= byte_nxt;
			status_q    <= status_nxt;
		end
	end

	assign out_valid     = out_valid_q;
	assign command_valid = cmd_valid_q;
	assign command_byte  = cmd_byte_q;
	assign frame_status  = status_q;

endmodule

`default_nettype wire

// ===== hw/rtl/command_frame_parser_crc16.sv =====
// Command frame parser with CRC-16/CCITT-FALSE check, top level.
// Each accepted byte is tagged, queued and, once the back end takes it, registered
// as its result beat. Throughput: one byte per cycle while the queue is not full;
// the four-entry queue between the classifying front end and the CRC back end
// absorbs output stalls. Reset: arst_n clears the parser to the sync hunt and both
// config registers to zero; every byte yields exactly one result beat.
`default_nettype none

module command_frame_parser_crc16 #(
	parameter int MAX_PAYLOAD = 4
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_tvalid,
	output logic              s_tready,
	input  wire logic [7:0]   s_tdata,   // [7:0] rx_byte
	output logic              m_tvalid,
	input  wire logic         m_tready,
	output logic [15:0]       m_tdata,   // [0] command_valid, [8:1] command_byte,
	                                     // [11:9] frame_status, [15:12] zero
	input  wire logic         cfg_we,
	input  wire logic         cfg_index,
	input  wire logic [7:0]   cfg_data
);
	import cfp_pkg::*;

	logic [7:0]  expected_version_q;
	logic [7:0]  command_type_q;
	token_t      front_tok;
	token_t      head_tok;
	logic        q_full;
	logic        head_valid;
	logic        take;
	logic        accept;
	logic        command_valid;
	logic [7:0]  command_byte;
	logic [2:0]  frame_status;

	assign s_tready = !q_full;
	assign accept   = s_tvalid && s_tready;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expected_version_q <= '0;
			command_type_q     <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_VERSION: expected_version_q <= cfg_data;
				CFG_TYPE:    command_type_q     <= cfg_data;
				default: ;
			endcase
		end
	end

	cfp_front #(
		.MAX_PAYLOAD(MAX_PAYLOAD)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (accept),
		.in_byte  (s_tdata),
		.tok      (front_tok)
	);

	cfp_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (accept),
		.push_tok   (front_tok),
		.full       (q_full),
		.head_valid (head_valid),
		.pop        (take),
		.head_tok   (head_tok)
	);

	cfp_back u_back (
		.clk              (clk),
		.arst_n           (arst_n),
		.tok_valid        (head_valid),
		.tok              (head_tok),
		.tok_take         (take),
		.expected_version (expected_version_q),
		.command_type     (command_type_q),
		.out_valid        (m_tvalid),
		.out_ready        (m_tready),
		.command_valid    (command_valid),
		.command_byte     (command_byte),
		.frame_status     (frame_status)
	);

	// Result beat packing, first field in the lowest bit.
	assign m_tdata = {4'b0000, frame_status, command_byte, command_valid};

endmodule

`default_nettype wire

// ===== tb/sv/command_frame_parser_crc16_tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for command_frame_parser_crc16: directed frames, then random frames.
// Random stalls on both stream sides, and the result of every beat is checked against a predictor.
// Depends on cfp_pkg and the command_frame_parser_crc16 RTL.

module command_frame_parser_crc16_tb;
	import cfp_pkg::*;

	localparam int MAX_PAYLOAD = 4;
	localparam int CYCLE_LIMIT = 500000;
	localparam int HOLD_CYCLES = 400;
	localparam int PHASE_BYTES = 130;
	localparam int PHASE_COUNT = 6;
	localparam int DIRECTED_ROWS = 32;

	// Where a directed byte comes from: the table itself or the running CRC.
	typedef enum logic [1:0] {
		BYTE_LITERAL,
		BYTE_CRC_LO,
		BYTE_CRC_HI
	} byte_src_t;

	// Kinds of random traffic.
	typedef enum logic [2:0] {
		SHAPE_COMMAND,
		SHAPE_OTHER,
		SHAPE_BAD_CRC,
		SHAPE_TOO_LONG,
		SHAPE_NOISE,
		SHAPE_CUT
	} frame_shape_t;

	// What the parser reports for one byte.
	typedef struct packed {
		logic       valid;
		logic [7:0] cmd;
		status_t    status;
	} frame_verdict_t;

	typedef struct packed {
		byte_src_t  src;
		logic [7:0] value;
		logic       typed;
		logic       exp_valid;
		logic [7:0] exp_cmd;
		status_t    exp_status;
	} directed_row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = 8'h00;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [15:0] m_tdata;
	logic        cfg_we = 1'b0;
	logic        cfg_index = CFG_VERSION;
	logic [7:0]  cfg_data = 8'h00;

	// Predictor state, starting from the reset values.
	phase_t      parse_ph = PH_SYNC1;
	logic [7:0]  seen_version = 8'h00;
	logic [7:0]  seen_type = 8'h00;
	logic [15:0] seen_length = 16'h0000;
	logic [2:0]  payload_seen = 3'd0;
	logic [7:0]  first_payload = 8'h00;
	logic [7:0]  crc_low_rx = 8'h00;
	logic [15:0] crc_run = 16'h0000;
	logic [7:0]  filter_version = 8'h00;
	logic [7:0]  filter_type = 8'h00;

	frame_verdict_t verdicts_due[$];
	logic [7:0]     tx_bytes[$];
	logic [15:0]    frame_crc;
	logic           hold_req = 1'b0;
	int             fail_count = 0;
	int             cycle_count = 0;

	// Directed frames under the reset configuration: a command with a repeated sync byte,
	// a frame whose length is far too long, and a zero-length frame that is not a command.
	directed_row_t directed_rows [DIRECTED_ROWS] = '{
		'{BYTE_LITERAL, 8'hA5, 1'b0, 1'b0, 8'h00, ST_BUSY},
		'{BYTE_LITERAL, 8'hA5, 1'b0, 1'b0, 8'h00, ST_BUSY},
		'{BYTE_LITERAL, 8'h5A, 1'b0, 1'b0, 8'h00, ST_BUSY},
		'{BYTE_LITERAL, 8'h00, 1'b0, 1'b0, 8'h00, ST_BUSY},
		'{BYTE_LITERAL, 8'h00, 1'b0, 1'b0, 8'h00, ST_BUSY},
		'{BYTE_LITERAL, 8'h01, 1'b0, 1'b0, 8'h00, ST_BUSY},
		'{BYTE_LITERAL, 8'h00, 1'b0, 1'b0, 8'h00, ST_BUSY},
		'{BYTE_LITERAL, 8'h00, 1'b0, 1'b0, 8'h00, ST_BUSY},
		'{BYTE_LITERAL, 8'hFF, 1'b0, 1'b0, 8'h00, ST_BUSY},
		'{BYTE_LITERAL, 8'h00, 1'b0, 1'b0, 8'h00, ST_BUSY},
		'{BYTE_LITERAL, 8'hFF, 1'b0, 1'b0, 8'h00, ST_BUSY},
		'{BYTE_LITERAL, 8'h3C, 1'b0, 1'b0, 8'h00, ST_BUSY},
		'{BYTE_CRC_LO,  8'h00, 1'b0, 1'b0, 8'h00, ST_BUSY},
		'{BYTE_CRC_HI,  8'h00, 1'b1, 1'b1, 8'h3C, ST_ACCEPT},
		'{BYTE_LITERAL, 8'hA5, 1'b0, 1'b0, 8'h00, ST_BUSY},
		'{BYTE_LITERAL, 8'h5A, 1'b0, 1'b0, 8'h00, ST_BUSY},
		'{BYTE_LITERAL, 8'hFF, 1'b0, 1'b0, 8'h00, ST_BUSY},
		'{BYTE_LITERAL, 8'hFF, 1'b0, 1'b0, 8'h00, ST_BUSY},
		'{BYTE_LITERAL, 8'h00, 1'b0, 1'b0, 8'h00, ST_BUSY},
		'{BYTE_LITERAL, 8'hFF, 1'b1, 1'b0, 8'h00, ST_TOO_LONG},
		'{BYTE_LITERAL, 8'hA5, 1'b0, 1'b0, 8'h00, ST_BUSY},
		'{BYTE_LITERAL, 8'h5A, 1'b0, 1'b0, 8'h00, ST_BUSY},
		'{BYTE_LITERAL, 8'hFF, 1'b0, 1'b0, 8'h00, ST_BUSY},
		'{BYTE_LITERAL, 8'h00, 1'b0, 1'b0, 8'h00, ST_BUSY},
		'{BYTE_LITERAL, 8'h00, 1'b0, 1'b0, 8'h00, ST_BUSY},
		'{BYTE_LITERAL, 8'h00, 1'b0, 1'b0, 8'h00, ST_BUSY},
		'{BYTE_LITERAL, 8'hFF, 1'b0, 1'b0, 8'h00, ST_BUSY},
		'{BYTE_LITERAL, 8'h00, 1'b0, 1'b0, 8'h00, ST_BUSY},
		'{BYTE_LITERAL, 8'hFF, 1'b0, 1'b0, 8'h00, ST_BUSY},
		'{BYTE_LITERAL, 8'h00, 1'b0, 1'b0, 8'h00, ST_BUSY},
		'{BYTE_CRC_LO,  8'h00, 1'b0, 1'b0, 8'h00, ST_BUSY},
		'{BYTE_CRC_HI,  8'h00, 1'b1, 1'b0, 8'h00, ST_NOT_CMD}
	};

	command_frame_parser_crc16 #(
		.MAX_PAYLOAD(MAX_PAYLOAD)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// CRC-16/CCITT-FALSE, one bit at a time from the MSB of the byte.
	function automatic logic [15:0] crc_ccitt_step(input logic [15:0] acc, input logic [7:0] d);
		logic [15:0] c;
		logic        fb;
		c = acc;
		for (int k = 7; k >= 0; k--) begin
			fb = c[15] ^ d[k];
			c = {c[14:0], 1'b0};
			if (fb) begin
				c = c ^ CRC_POLY;
			end
		end
		return c;
	endfunction

	// Frame end or abort: back to the sync hunt, version and type fields are kept.
	function automatic void drop_to_hunt();
		parse_ph = PH_SYNC1;
		seen_length = 16'h0000;
		payload_seen = 3'd0;
		crc_low_rx = 8'h00;
		crc_run = 16'h0000;
	endfunction

	// Advances the predicted parser by one byte and returns what it reports.
	function automatic frame_verdict_t predict_verdict(input logic [7:0] b);
		frame_verdict_t v;
		v.valid = 1'b0;
		v.cmd = 8'h00;
		v.status = ST_BUSY;
		case (parse_ph)
			PH_SYNC1: begin
				if (b == SYNC_FIRST) begin
					parse_ph = PH_SYNC2;
				end
			end
			PH_SYNC2: begin
				if (b == SYNC_SECOND) begin
					crc_run = CRC_INIT;
					payload_seen = 3'd0;
					parse_ph = PH_VER;
				end else if (b == SYNC_FIRST) begin
					parse_ph = PH_SYNC2;
				end else begin
					parse_ph = PH_SYNC1;
				end
			end
			PH_VER: begin
				seen_version = b;
				crc_run = crc_ccitt_step(crc_run, b);
				parse_ph = PH_TYPE;
			end
			PH_TYPE: begin
				seen_type = b;
				crc_run = crc_ccitt_step(crc_run, b);
				parse_ph = PH_LEN_LO;
			end
			PH_LEN_LO: begin
				seen_length = {8'h00, b};
				crc_run = crc_ccitt_step(crc_run, b);
				parse_ph = PH_LEN_HI;
			end
			PH_LEN_HI: begin
				seen_length[15:8] = b;
				crc_run = crc_ccitt_step(crc_run, b);
				if (seen_length > 16'(MAX_PAYLOAD)) begin
					v.status = ST_TOO_LONG;
					drop_to_hunt();
				end else begin
					parse_ph = PH_SEQ0;
				end
			end
			PH_SEQ0, PH_SEQ1, PH_SEQ2: begin
				crc_run = crc_ccitt_step(crc_run, b);
				parse_ph = phase_t'(parse_ph + 1);
			end
			PH_SEQ3: begin
				crc_run = crc_ccitt_step(crc_run, b);
				parse_ph = (seen_length == 16'h0000) ? PH_CRC_LO : PH_DATA;
			end
			PH_DATA: begin
				if (payload_seen == 3'd0) begin
					first_payload = b;
				end
				payload_seen = payload_seen + 3'd1;
				crc_run = crc_ccitt_step(crc_run, b);
				if ({13'd0, payload_seen} >= seen_length) begin
					parse_ph = PH_CRC_LO;
				end
			end
			PH_CRC_LO: begin
				crc_low_rx = b;
				parse_ph = PH_CRC_HI;
			end
			PH_CRC_HI: begin
				if ({b, crc_low_rx} != crc_run) begin
					v.status = ST_CRC_BAD;
				end else if (seen_version == filter_version && seen_type == filter_type &&
						seen_length == 16'd1) begin
					v.status = ST_ACCEPT;
					v.valid = 1'b1;
					v.cmd = first_payload;
				end else begin
					v.status = ST_NOT_CMD;
				end
				drop_to_hunt();
			end
			default: begin
				drop_to_hunt();
			end
		endcase
		return v;
	endfunction

	// Mostly no gap, sometimes a short one, rarely a long one.
	function automatic int next_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 70) begin
			return 0;
		end else if (r < 95) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(10, 40);
	endfunction

	// Adds a byte to the frame under construction and to its CRC.
	function automatic void push_covered(input logic [7:0] d);
		tx_bytes.push_back(d);
		frame_crc = crc_ccitt_step(frame_crc, d);
	endfunction

	// Offers one byte, waits for the beat, and queues the verdict it should produce.
	task automatic send_rx_byte(input logic [7:0] b, input int gap, input logic typed,
			input frame_verdict_t typed_v);
		frame_verdict_t v;
		@(negedge clk);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= b;
		do @(posedge clk); while (!s_tready);
		v = predict_verdict(b);
		verdicts_due.push_back(typed ? typed_v : v);
	endtask

	// Stops offering bytes and waits until every verdict has come back.
	task automatic settle_parser();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (verdicts_due.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	// Writes both filter registers on consecutive cycles.
	task automatic set_filter(input logic [7:0] ver, input logic [7:0] typ);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= CFG_VERSION;
		cfg_data <= ver;
		@(negedge clk);
		cfg_index <= CFG_TYPE;
		cfg_data <= typ;
		@(negedge clk);
		cfg_we <= 1'b0;
		filter_version = ver;
		filter_type = typ;
	endtask

	// Stimulus: reset, directed table, then random phases under different filters.
	initial begin
		logic [7:0]   rx;
		logic [7:0]   f_ver;
		logic [7:0]   f_type;
		logic [15:0]  f_len;
		logic         smooth;
		frame_shape_t shape;
		int           shape_pick;
		int           cut;
		int           phase_bytes;
		int           r;

		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		for (int i = 0; i < DIRECTED_ROWS; i++) begin
			case (directed_rows[i].src)
				BYTE_CRC_LO: rx = crc_run[7:0];
				BYTE_CRC_HI: rx = crc_run[15:8];
				default:     rx = directed_rows[i].value;
			endcase
			send_rx_byte(rx, next_gap(), directed_rows[i].typed,
				'{directed_rows[i].exp_valid, directed_rows[i].exp_cmd,
				directed_rows[i].exp_status});
		end

		for (int p = 0; p < PHASE_COUNT; p++) begin
			settle_parser();
			case (p)
				0:       set_filter(8'hFF, 8'hFF);
				1:       set_filter(8'h00, 8'hFF);
				2:       set_filter(8'hFF, 8'h00);
				3:       set_filter(8'h00, 8'h00);
				default: set_filter(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
			endcase
			// Once, the receiver stops for a long time while bytes keep coming.
			if (p == 1) begin
				hold_req = 1'b1;
			end
			phase_bytes = 0;
			while (phase_bytes < PHASE_BYTES) begin
				shape_pick = $urandom_range(0, 99);
				if (shape_pick < 45) begin
					shape = SHAPE_COMMAND;
				end else if (shape_pick < 60) begin
					shape = SHAPE_OTHER;
				end else if (shape_pick < 72) begin
					shape = SHAPE_BAD_CRC;
				end else if (shape_pick < 82) begin
					shape = SHAPE_TOO_LONG;
				end else if (shape_pick < 94) begin
					shape = SHAPE_NOISE;
				end else begin
					shape = SHAPE_CUT;
				end

				tx_bytes.delete();
				if (shape == SHAPE_NOISE) begin
					// Line noise, rich in sync bytes.
					repeat ($urandom_range(1, 6)) begin
						r = $urandom_range(0, 9);
						if (r < 2) begin
							rx = SYNC_FIRST;
						end else if (r < 3) begin
							rx = SYNC_SECOND;
						end else begin
							rx = 8'($urandom_range(0, 255));
						end
						tx_bytes.push_back(rx);
					end
				end else begin
					if ($urandom_range(0, 3) == 0) begin
						repeat ($urandom_range(1, 2)) tx_bytes.push_back(SYNC_FIRST);
					end
					tx_bytes.push_back(SYNC_FIRST);
					tx_bytes.push_back(SYNC_SECOND);
					if (shape == SHAPE_COMMAND || shape == SHAPE_CUT) begin
						f_ver = filter_version;
						f_type = filter_type;
						f_len = 16'd1;
					end else begin
						f_ver = $urandom_range(0, 1) ? filter_version :
							8'($urandom_range(0, 255));
						f_type = $urandom_range(0, 1) ? filter_type :
							8'($urandom_range(0, 255));
						if (shape == SHAPE_TOO_LONG) begin
							case ($urandom_range(0, 3))
								0:       f_len = 16'(MAX_PAYLOAD + 1);
								1:       f_len = 16'hFFFF;
								2:       f_len = 16'($urandom_range(MAX_PAYLOAD + 1, 255));
								default: f_len = 16'($urandom_range(256, 65535));
							endcase
						end else begin
							f_len = 16'($urandom_range(0, MAX_PAYLOAD));
						end
					end
					frame_crc = CRC_INIT;
					push_covered(f_ver);
					push_covered(f_type);
					push_covered(f_len[7:0]);
					push_covered(f_len[15:8]);
					if (shape != SHAPE_TOO_LONG) begin
						repeat (4) push_covered(8'($urandom_range(0, 255)));
						repeat (f_len) push_covered(8'($urandom_range(0, 255)));
						if (shape == SHAPE_BAD_CRC) begin
							frame_crc = frame_crc ^ 16'($urandom_range(1, 65535));
						end
						tx_bytes.push_back(frame_crc[7:0]);
						tx_bytes.push_back(frame_crc[15:8]);
						// A frame that breaks off leaves the parser mid-frame.
						if (shape == SHAPE_CUT) begin
							cut = $urandom_range(3, tx_bytes.size() - 2);
							while (tx_bytes.size() > cut) void'(tx_bytes.pop_back());
						end
					end
				end

				smooth = ($urandom_range(0, 3) == 0);
				foreach (tx_bytes[k]) begin
					send_rx_byte(tx_bytes[k], smooth ? 0 : next_gap(), 1'b0, '0);
				end
				phase_bytes += tx_bytes.size();
			end
		end

		settle_parser();
		if (fail_count == 0) begin
			$display("command_frame_parser_crc16: match");
		end else begin
			$display("command_frame_parser_crc16: mismatch");
		end
		$finish;
	end

	// Receiver: runs of ready and stalled cycles, plus the one long hold-off.
	initial begin
		int   run_left;
		int   r;
		logic ready_next;
		run_left = 0;
		ready_next = 1'b1;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
			end else begin
				if (run_left == 0) begin
					r = $urandom_range(0, 99);
					if (r < 20) begin
						ready_next = 1'b1;
						run_left = $urandom_range(50, 150);
					end else if (r < 70) begin
						ready_next = 1'b1;
						run_left = $urandom_range(1, 8);
					end else if (r < 95) begin
						ready_next = 1'b0;
						run_left = $urandom_range(1, 3);
					end else begin
						ready_next = 1'b0;
						run_left = $urandom_range(10, 40);
					end
				end
				m_tready <= ready_next;
				run_left--;
			end
		end
	end

	// Each result beat is compared with the oldest expected verdict.
	always @(posedge clk) begin : check_results
		frame_verdict_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (verdicts_due.size() == 0) begin
				$error("result beat %h with no byte waiting for it", m_tdata);
				fail_count++;
			end else begin
				want = verdicts_due.pop_front();
				if (m_tdata[0] !== want.valid) begin
					$error("command_valid: expected %0d, got %0d", want.valid, m_tdata[0]);
					fail_count++;
				end
				if (m_tdata[8:1] !== want.cmd) begin
					$error("command_byte: expected %02h, got %02h", want.cmd, m_tdata[8:1]);
					fail_count++;
				end
				if (m_tdata[11:9] !== want.status) begin
					$error("frame_status: expected %0d, got %0d", want.status, m_tdata[11:9]);
					fail_count++;
				end
			end
		end
	end

	// Watchdog for a hung handshake.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("command_frame_parser_crc16: mismatch");
			$finish;
		end
	end

endmodule
